### hdl/assert_macros.svh
// assertion helpers for the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### hdl/puil_pkg.sv
`default_nettype none

package puil_pkg;

   // default list capacity
   localparam int PUIL_CAPACITY = 16;

   // operation codes
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_SEARCH = 2'd2;

   // status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_BAD_POS   = 3'd1;
   localparam logic [2:0] ST_DUPLICATE = 3'd2;
   localparam logic [2:0] ST_FULL      = 3'd3;
   localparam logic [2:0] ST_NOT_FOUND = 3'd4;
   localparam logic [2:0] ST_EMPTY     = 3'd5;

   // request transaction
   typedef struct packed {
      logic [1:0]         operation;
      logic signed [31:0] book_id;
      logic [7:0]         position;
   } puil_req_type;

   // response transaction
   typedef struct packed {
      logic [2:0] status;
      logic [4:0] found_position;
      logic [4:0] entry_count;
   } puil_rsp_type;

endpackage

`default_nettype wire

### hdl/positional_unique_id_list_top.sv
// sequence: a refusal, the unused code or an empty search is answered straight from idle;
//    a search or insert first scans for the key, an accepted insert then moves entries
//    up to open its slot, and a remove moves entries down to close the gap
// throughput: one transaction at a time; busy drops in the response cycle, start taken then
// reset: synchronous, clears count and sequencer; store contents are not cleared
`default_nettype none

`include "assert_macros.svh"

module positional_unique_id_list_top #(
   parameter int CAPACITY = puil_pkg::PUIL_CAPACITY
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire puil_pkg::puil_req_type req_data,
   output logic                       rsp_strobe,
   output puil_pkg::puil_rsp_type     rsp_data
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = ((CW > 8) ? CW : 8) + 1;

   // sequencer states
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_SHUP = 2'd2;
   localparam logic [1:0] S_SHDN = 2'd3;

   logic [1:0]    state_ff, state_in;
   logic [1:0]    op_ff, op_in;
   logic [31:0]   key_ff, key_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] chk_ff, chk_in;
   logic          chk_vld_ff, chk_vld_in;
   logic          rsp_strobe_ff, rsp_strobe_in;
   puil_pkg::puil_rsp_type rsp_data_ff, rsp_data_in;

   logic [31:0]   mem [CAPACITY];
   logic [31:0]   rd_data_ff;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [31:0]   wr_data;

   logic [PW-1:0] pos_w, cnt_w;
   logic [CW+4:0] found_wide, count_wide;

   assign pos_w = PW'(req_data.position);
   assign cnt_w = PW'(count_ff);

   // store: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      pos_in        = pos_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      chk_in        = chk_ff;
      chk_vld_in    = 1'b0;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = rd_data_ff;
      found_wide    = '0;
      count_wide    = '0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in  = req_data.operation;
               key_in = req_data.book_id;
               idx_in = '0;
               rsp_data_in.status         = puil_pkg::ST_OK;
               rsp_data_in.found_position = '0;
               count_wide = {5'b0, count_ff};
               rsp_data_in.entry_count    = count_wide[4:0];
               case (req_data.operation)
                  puil_pkg::OP_INSERT: begin
                     if (pos_w == '0 || pos_w > cnt_w + PW'(1)) begin
                        rsp_data_in.status = puil_pkg::ST_BAD_POS;
                        rsp_strobe_in      = 1'b1;
                     end else begin
                        pos_in   = CW'(pos_w - PW'(1));
                        state_in = S_SCAN;
                     end
                  end
                  puil_pkg::OP_REMOVE: begin
                     if (pos_w == '0 || pos_w > cnt_w) begin
                        rsp_data_in.status = puil_pkg::ST_BAD_POS;
                        rsp_strobe_in      = 1'b1;
                     end else begin
                        pos_in   = CW'(pos_w - PW'(1));
                        idx_in   = CW'(pos_w - PW'(1));
                        state_in = S_SHDN;
                     end
                  end
                  puil_pkg::OP_SEARCH: begin
                     if (count_ff == '0) begin
                        rsp_data_in.status = puil_pkg::ST_EMPTY;
                        rsp_strobe_in      = 1'b1;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end

         // walk the list, compare one entry a cycle
         S_SCAN: begin
            if (idx_ff < count_ff) begin
               rd_addr    = AW'(idx_ff);
               chk_vld_in = 1'b1;
               chk_in     = idx_ff;
               idx_in     = idx_ff + CW'(1);
            end
            if (chk_vld_ff && rd_data_ff == key_ff) begin
               state_in      = S_IDLE;
               rsp_strobe_in = 1'b1;
               chk_vld_in    = 1'b0;
               if (op_ff == puil_pkg::OP_SEARCH) begin
                  found_wide = {5'b0, chk_ff + CW'(1)};
                  rsp_data_in.found_position = found_wide[4:0];
               end else begin
                  rsp_data_in.status = puil_pkg::ST_DUPLICATE;
               end
            end else if (!chk_vld_ff && idx_ff >= count_ff) begin
               if (op_ff == puil_pkg::OP_SEARCH) begin
                  state_in           = S_IDLE;
                  rsp_strobe_in      = 1'b1;
                  rsp_data_in.status = puil_pkg::ST_NOT_FOUND;
               end else if (count_ff >= CW'(CAPACITY)) begin
                  state_in           = S_IDLE;
                  rsp_strobe_in      = 1'b1;
                  rsp_data_in.status = puil_pkg::ST_FULL;
               end else begin
                  state_in = S_SHUP;
                  idx_in   = count_ff;
               end
            end
         end

         // move entries up from the tail, then drop the key in
         S_SHUP: begin
            if (idx_ff > pos_ff) begin
               rd_addr    = AW'(idx_ff - CW'(1));
               chk_vld_in = 1'b1;
               chk_in     = idx_ff;
               idx_in     = idx_ff - CW'(1);
            end
            if (chk_vld_ff) begin
               wr_en   = 1'b1;
               wr_addr = AW'(chk_ff);
               wr_data = rd_data_ff;
            end else if (idx_ff == pos_ff) begin
               wr_en         = 1'b1;
               wr_addr       = AW'(pos_ff);
               wr_data       = key_ff;
               count_in      = count_ff + CW'(1);
               count_wide    = {5'b0, count_ff + CW'(1)};
               rsp_data_in.entry_count = count_wide[4:0];
               rsp_strobe_in = 1'b1;
               state_in      = S_IDLE;
            end
         end

         // close the gap, moving entries down toward the head
         S_SHDN: begin
            if (idx_ff + CW'(1) < count_ff) begin
               rd_addr    = AW'(idx_ff + CW'(1));
               chk_vld_in = 1'b1;
               chk_in     = idx_ff;
               idx_in     = idx_ff + CW'(1);
            end
            if (chk_vld_ff) begin
               wr_en   = 1'b1;
               wr_addr = AW'(chk_ff);
               wr_data = rd_data_ff;
            end else if (!(idx_ff + CW'(1) < count_ff)) begin
               count_in      = count_ff - CW'(1);
               count_wide    = {5'b0, count_ff - CW'(1)};
               rsp_data_in.entry_count = count_wide[4:0];
               rsp_strobe_in = 1'b1;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         chk_vld_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         chk_vld_ff    <= chk_vld_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // transaction payload registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      key_ff      <= key_in;
      pos_ff      <= pos_in;
      idx_ff      <= idx_in;
      chk_ff      <= chk_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   // checks
   `ASSERT_IMPLIES(a_count_cap, clock, reset, 1'b1, count_ff <= CW'(CAPACITY))
   `ASSERT_NEXT(a_start_answered, clock, reset, start && !busy, busy || rsp_strobe)
   `ASSERT_IMPLIES(a_fall_responds, clock, reset, $fell(busy), rsp_strobe)
   `ASSERT_IMPLIES(a_idle_no_write, clock, reset, !busy, !wr_en)

endmodule

`default_nettype wire

### tb/tb.sv
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // operation code that the block leaves unused
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int         LIST_CAP  = puil_pkg::PUIL_CAPACITY;
   localparam int         POOL_SIZE = 32;
   localparam int         SETTLE_CYCLES = 60;
   localparam int         DRAIN_LIMIT   = 4000;

   logic                   clock;
   logic                   reset;
   logic                   start;
   wire                    busy;
   puil_pkg::puil_req_type req_data;
   wire                    rsp_strobe;
   puil_pkg::puil_rsp_type rsp_data;

   // shadow copy of the list
   logic signed [31:0] id_list [LIST_CAP];
   int                 list_len;
   logic signed [31:0] id_pool [POOL_SIZE];

   puil_pkg::puil_rsp_type expected_rsps[$];
   puil_pkg::puil_rsp_type oldest_rsp;

   int fail_count;
   int sent_count;
   int peak_len;
   int op_count [4];
   int status_count [6];

   positional_unique_id_list_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   // clock, 8 ns period
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // index of the first entry holding key, or list_len when absent
   function automatic int find_entry(logic signed [31:0] key);
      int k;
      for (k = 0; k < list_len; k++) begin
         if (id_list[k] == key) return k;
      end
      return list_len;
   endfunction

   // apply one transaction to the shadow list and return the expected response
   function automatic puil_pkg::puil_rsp_type apply_list_op(puil_pkg::puil_req_type r);
      puil_pkg::puil_rsp_type rsp;
      int                     hit;
      int                     pos;
      int                     k;
      rsp.status         = puil_pkg::ST_OK;
      rsp.found_position = '0;
      hit = find_entry(r.book_id);
      pos = int'(r.position);
      case (r.operation)
         puil_pkg::OP_INSERT: begin
            if (pos < 1 || pos > list_len + 1) begin
               rsp.status = puil_pkg::ST_BAD_POS;
            end else if (hit < list_len) begin
               rsp.status = puil_pkg::ST_DUPLICATE;
            end else if (list_len >= LIST_CAP) begin
               rsp.status = puil_pkg::ST_FULL;
            end else begin
               // open a slot at pos
               for (k = list_len; k > pos - 1; k--) id_list[k] = id_list[k - 1];
               id_list[pos - 1] = r.book_id;
               list_len++;
            end
         end
         puil_pkg::OP_REMOVE: begin
            if (pos < 1 || pos > list_len) begin
               rsp.status = puil_pkg::ST_BAD_POS;
            end else begin
               // close the gap
               for (k = pos - 1; k + 1 < list_len; k++) id_list[k] = id_list[k + 1];
               list_len--;
            end
         end
         puil_pkg::OP_SEARCH: begin
            if (list_len == 0) begin
               rsp.status = puil_pkg::ST_EMPTY;
            end else if (hit < list_len) begin
               rsp.found_position = 5'(hit + 1);
            end else begin
               rsp.status = puil_pkg::ST_NOT_FOUND;
            end
         end
         default: begin
         end
      endcase
      rsp.entry_count = 5'(list_len);
      return rsp;
   endfunction

   // drive one transaction and wait until the block takes it
   task automatic send_item(input logic [1:0] op, input logic signed [31:0] id,
                            input logic [7:0] pos);
      puil_pkg::puil_req_type r;
      puil_pkg::puil_rsp_type rsp;
      r.operation = op;
      r.book_id   = id;
      r.position  = pos;
      @(negedge clock);
      start    = 1'b1;
      req_data = r;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      rsp = apply_list_op(r);
      expected_rsps.push_back(rsp);
      sent_count++;
      op_count[op]++;
      if (rsp.status < 6) status_count[rsp.status]++;
      if (list_len > peak_len) peak_len = list_len;
   endtask

   // sender gap
   task automatic idle_cycles(input int n);
      @(negedge clock);
      start = 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // hold off until every expected response has come, with a bound
   task automatic wait_drained();
      int guard;
      @(negedge clock);
      start = 1'b0;
      guard = 0;
      while (expected_rsps.size() != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      if (expected_rsps.size() != 0) begin
         $error("%0d response transactions never arrived", expected_rsps.size());
         fail_count++;
         expected_rsps.delete();
      end
   endtask

   // id for random traffic: stored ids, a small pool, or anything
   function automatic logic signed [31:0] pick_id();
      int r;
      r = $urandom_range(0, 99);
      if (list_len > 0 && r < 40) return id_list[$urandom_range(0, list_len - 1)];
      if (r < 75) return id_pool[$urandom_range(0, POOL_SIZE - 1)];
      return $urandom;
   endfunction

   // position for random traffic: mostly in range, sometimes just outside or wild
   function automatic logic [7:0] pick_pos(input logic [1:0] op);
      int r;
      int top;
      r   = $urandom_range(0, 99);
      top = (op == puil_pkg::OP_INSERT) ? list_len + 1 : list_len;
      if (r < 80) return 8'($urandom_range(1, (top < 1) ? 1 : top));
      if (r < 88) return 8'd0;
      if (r < 94) return 8'(top + 1);
      return 8'($urandom_range(0, 255));
   endfunction

   // random transactions with a drifting insert bias so the fill level sweeps
   task automatic run_random(input int n, input bit allow_idle, input int drain_every);
      int         i;
      int         r;
      int         insert_weight;
      bit         idle_on;
      logic [1:0] op;
      insert_weight = 50;
      idle_on       = allow_idle;
      for (i = 0; i < n; i++) begin
         if (i % 64 == 0) insert_weight = $urandom_range(25, 80);
         if (allow_idle && i % 100 == 0) idle_on = ($urandom_range(0, 2) != 0);
         r = $urandom_range(0, 99);
         if (r < 2) op = OP_UNUSED;
         else if (r < insert_weight) op = puil_pkg::OP_INSERT;
         else if (r % 2 == 0) op = puil_pkg::OP_REMOVE;
         else op = puil_pkg::OP_SEARCH;
         send_item(op, pick_id(), pick_pos(op));
         if (idle_on && $urandom_range(0, 7) == 0) idle_cycles($urandom_range(1, 14));
         if (drain_every > 0 && i % drain_every == drain_every - 1) wait_drained();
      end
   endtask

   // operations on a list that has never been written
   task automatic test_empty_list();
      send_item(puil_pkg::OP_SEARCH, 32'sd0, 8'd0);
      send_item(puil_pkg::OP_REMOVE, 32'sd7, 8'd0);
      send_item(puil_pkg::OP_REMOVE, 32'sd7, 8'd1);
      send_item(puil_pkg::OP_INSERT, 32'sd5, 8'd2);
   endtask

   // extreme ids and positions, refusals, and the unused code
   task automatic test_field_extremes();
      send_item(puil_pkg::OP_INSERT, 32'sh8000_0000, 8'd0);
      send_item(puil_pkg::OP_INSERT, 32'sh8000_0000, 8'd1);
      send_item(puil_pkg::OP_INSERT, 32'sh7fff_ffff, 8'd2);
      send_item(puil_pkg::OP_INSERT, 32'sh7fff_ffff, 8'd1);
      send_item(puil_pkg::OP_INSERT, -32'sd1, 8'd255);
      send_item(puil_pkg::OP_SEARCH, 32'sh8000_0000, 8'd255);
      send_item(puil_pkg::OP_SEARCH, 32'sh7fff_ffff, 8'd0);
      send_item(puil_pkg::OP_SEARCH, -32'sd1, 8'd1);
      send_item(OP_UNUSED, 32'sh7fff_ffff, 8'd1);
      send_item(puil_pkg::OP_REMOVE, 32'sd0, 8'd3);
      send_item(puil_pkg::OP_REMOVE, 32'sd0, 8'd255);
   endtask

   // fill to capacity, then refusals on a full list and removes at both ends
   task automatic test_full_list();
      int k;
      k = 0;
      while (list_len < LIST_CAP) begin
         send_item(puil_pkg::OP_INSERT, 32'sh5a5a_0000 + k,
                   8'((k % 3 == 0) ? 1 : (k % 3 == 1) ? list_len + 1 : (list_len + 1) / 2));
         k++;
      end
      send_item(puil_pkg::OP_INSERT, 32'sh1234_5678, 8'd1);
      send_item(puil_pkg::OP_INSERT, 32'sh1234_5678, 8'(LIST_CAP + 1));
      send_item(puil_pkg::OP_INSERT, 32'sh8000_0000, 8'd1);
      send_item(puil_pkg::OP_INSERT, 32'sh1234_5678, 8'(LIST_CAP + 2));
      send_item(puil_pkg::OP_SEARCH, id_list[LIST_CAP - 1], 8'd0);
      send_item(puil_pkg::OP_REMOVE, 32'sd0, 8'(LIST_CAP + 1));
      send_item(puil_pkg::OP_REMOVE, 32'sd0, 8'(LIST_CAP));
      send_item(puil_pkg::OP_REMOVE, 32'sd0, 8'd1);
   endtask

   // bulk random traffic with sender gaps
   task automatic test_random_traffic();
      int k;
      for (k = 0; k < POOL_SIZE; k++) id_pool[k] = $urandom;
      id_pool[0] = 32'sh8000_0000;
      id_pool[1] = 32'sh7fff_ffff;
      id_pool[2] = 32'sd0;
      id_pool[3] = -32'sd1;
      run_random(1400, 1'b1, 0);
   endtask

   // sender pauses until the block has answered everything
   task automatic test_drain_pauses();
      wait_drained();
      run_random(200, 1'b1, 25);
   endtask

   // closing stretch, back to back
   task automatic test_back_to_back();
      run_random(150, 1'b0, 0);
   endtask

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_rsps.size() == 0) begin
            $error("response transaction with none expected: status %0d", rsp_data.status);
            fail_count++;
         end else begin
            oldest_rsp = expected_rsps.pop_front();
            if (rsp_data.status !== oldest_rsp.status) begin
               $error("status: expected %0d, actual %0d", oldest_rsp.status, rsp_data.status);
               fail_count++;
            end
            if (rsp_data.found_position !== oldest_rsp.found_position) begin
               $error("found_position: expected %0d, actual %0d",
                      oldest_rsp.found_position, rsp_data.found_position);
               fail_count++;
            end
            if (rsp_data.entry_count !== oldest_rsp.entry_count) begin
               $error("entry_count: expected %0d, actual %0d",
                      oldest_rsp.entry_count, rsp_data.entry_count);
               fail_count++;
            end
         end
      end
   end

   // main sequence
   initial begin
      reset      = 1'b1;
      start      = 1'b0;
      req_data   = '0;
      list_len   = 0;
      fail_count = 0;
      sent_count = 0;
      peak_len   = 0;
      for (int k = 0; k < 4; k++) op_count[k] = 0;
      for (int k = 0; k < 6; k++) status_count[k] = 0;
      for (int k = 0; k < LIST_CAP; k++) id_list[k] = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_list();
      test_field_extremes();
      test_full_list();
      test_random_traffic();
      test_drain_pauses();
      test_back_to_back();

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d transactions: %0d insert, %0d remove, %0d search, %0d unused",
               sent_count, op_count[puil_pkg::OP_INSERT], op_count[puil_pkg::OP_REMOVE],
               op_count[puil_pkg::OP_SEARCH], op_count[OP_UNUSED]);
      $display("peak fill %0d of %0d; refusals: %0d position, %0d duplicate, %0d full,",
               peak_len, LIST_CAP, status_count[puil_pkg::ST_BAD_POS],
               status_count[puil_pkg::ST_DUPLICATE], status_count[puil_pkg::ST_FULL]);
      $display("   %0d miss, %0d empty",
               status_count[puil_pkg::ST_NOT_FOUND], status_count[puil_pkg::ST_EMPTY]);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule

`default_nettype wire

### files.f
+incdir+hdl
hdl/puil_pkg.sv
hdl/positional_unique_id_list_top.sv
tb/tb.sv
